[rtl/vrg_pkg.sv]
package vrg_pkg;

    localparam int MAX_DIM = 256;
    localparam int COORD_W = 8;
    localparam int BOX_W   = 9;
    localparam int DENS_W  = 16;
    localparam int MASS_W  = 40;
    localparam int M1_W    = 48;
    localparam int M2_W    = 56;
    localparam int CM_W    = 57;
    localparam int NUM_W   = 59;
    localparam int FRAC_W  = 16;
    localparam int DVD_W   = NUM_W + FRAC_W;
    localparam int QUO_W   = 34;
    localparam int CNT_W   = 7;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z = 1'd1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       take;      // input transfer this cycle
        logic       clr;       // end of grid: clear coordinates and sums
        logic       div_axis;  // load divider with first moment of axis
        logic       div_gyr;   // load divider with central moment sum
        logic       div_step;  // one restoring step
        logic       k_lat;     // latch center of axis from quotient
        logic       mul1;      // k*k and 2k*S1
        logic       mul2;      // S2 + kk*M
        logic       num_clr;
        logic       num_add;
        logic       out_load;
        logic       out_empty;
        logic [1:0] axis;
    } t_cmd;

    typedef struct packed {
        logic m_zero;
        logic out_busy;
    } t_sts;

endpackage

[rtl/vrg_if.sv]
interface vrg_in_if;
    logic                         valid;
    logic                         ready;
    logic [vrg_pkg::DENS_W-1:0]   density;
    logic                         last;
    modport source (output valid, output density, output last, input ready);
    modport sink   (input valid, input density, input last, output ready);
endinterface

interface vrg_out_if;
    logic                         valid;
    logic                         ready;
    logic [vrg_pkg::MASS_W-1:0]   mass;
    logic [vrg_pkg::COORD_W-1:0]  center_x;
    logic [vrg_pkg::COORD_W-1:0]  center_y;
    logic [vrg_pkg::COORD_W-1:0]  center_z;
    logic [vrg_pkg::QUO_W-1:0]    gyration_sq;
    logic                         empty_grid;
    modport source (output valid, output mass, output center_x, output center_y,
                    output center_z, output gyration_sq, output empty_grid, input ready);
    modport sink   (input valid, input mass, input center_x, input center_y,
                    input center_z, input gyration_sq, input empty_grid, output ready);
endinterface

[rtl/vrg_ctrl.sv]
module vrg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last,
    output logic            o_ready,
    input  vrg_pkg::t_sts   i_sts,
    output vrg_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_ACC   = 3'd0;
    localparam logic [2:0] S_DRAIN = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_KLAT  = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_ADD   = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    localparam logic [1:0] AXIS_LAST = 2'd2;
    localparam logic [vrg_pkg::CNT_W-1:0] CNT_END = vrg_pkg::CNT_W'(vrg_pkg::DVD_W - 1);

    logic [2:0]                r_state, n_state;
    logic [1:0]                r_axis, n_axis;
    logic                      r_gyr, n_gyr;
    logic                      r_empty, n_empty;
    logic                      r_mul1, n_mul1;
    logic [vrg_pkg::CNT_W-1:0] r_cnt, n_cnt;

    assign o_ready = (r_state == S_ACC);

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        n_gyr   = r_gyr;
        n_empty = r_empty;
        n_mul1  = 1'b0;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        o_cmd.mul1 = r_mul1;
        unique case (r_state)
            S_ACC: begin
                o_cmd.take = i_valid;
                if (i_valid && i_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                o_cmd.num_clr = 1'b1;
                n_axis = 2'd0;
                n_gyr  = 1'b0;
                n_cnt  = '0;
                if (i_sts.m_zero) begin
                    n_empty = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_empty = 1'b0;
                    o_cmd.div_axis = 1'b1;
                    o_cmd.axis = 2'd0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_END) begin
                    n_cnt   = '0;
                    n_state = r_gyr ? S_FIN : S_KLAT;
                end
            end
            S_KLAT: begin
                o_cmd.k_lat = 1'b1;
                n_mul1  = 1'b1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                // products from the k*k step land this cycle; add S2 next
                if (!r_mul1) begin
                    o_cmd.mul2 = 1'b1;
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                o_cmd.num_add = 1'b1;
                if (r_axis == AXIS_LAST) begin
                    n_gyr = 1'b1;
                    o_cmd.div_gyr = 1'b1;
                end else begin
                    n_axis = r_axis + 1'b1;
                    o_cmd.div_axis = 1'b1;
                    o_cmd.axis = r_axis + 1'b1;
                end
                n_state = S_DIV;
            end
            S_FIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_empty = r_empty;
                    o_cmd.clr       = 1'b1;
                    n_state = S_ACC;
                end
            end
            default: n_state = S_ACC;
        endcase
    end

    // hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_axis  <= 2'd0;
            r_gyr   <= 1'b0;
            r_empty <= 1'b0;
            r_mul1  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
            r_gyr   <= n_gyr;
            r_empty <= n_empty;
            r_mul1  <= n_mul1;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[rtl/vrg_dp.sv]
module vrg_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [vrg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vrg_pkg::BOX_W-1:0]     i_cfg_data,
    input  logic [vrg_pkg::DENS_W-1:0]    i_density,
    input  vrg_pkg::t_cmd                 i_cmd,
    output vrg_pkg::t_sts                 o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [vrg_pkg::MASS_W-1:0]    o_mass,
    output logic [vrg_pkg::COORD_W-1:0]   o_center_x,
    output logic [vrg_pkg::COORD_W-1:0]   o_center_y,
    output logic [vrg_pkg::COORD_W-1:0]   o_center_z,
    output logic [vrg_pkg::QUO_W-1:0]     o_gyration_sq,
    output logic                          o_empty_grid
);

    localparam int CW = vrg_pkg::COORD_W;
    localparam int BW = vrg_pkg::BOX_W;
    localparam logic [BW-1:0] DIM_MAX = BW'(vrg_pkg::MAX_DIM);
    localparam logic [CW-1:0] K_SAT   = CW'(vrg_pkg::MAX_DIM - 1);

    logic [BW-1:0] r_box_y, r_box_z;
    logic [CW-1:0] r_cx, r_cy, r_cz;
    logic [BW-1:0] eff_y, eff_z, y_inc, z_inc;

    logic                        r_pv;
    logic [vrg_pkg::DENS_W-1:0]  r_v;
    logic [CW-1:0]               r_c  [3];
    logic [2*CW-1:0]             r_cs [3];
    logic [CW-1:0]               cur_c [3];

    logic [vrg_pkg::MASS_W-1:0]  r_m;
    logic [vrg_pkg::M1_W-1:0]    r_s1 [3];
    logic [vrg_pkg::M2_W-1:0]    r_s2 [3];

    logic [vrg_pkg::MASS_W-1:0]  r_rem;
    logic [vrg_pkg::DVD_W-1:0]   r_dvd;
    logic [vrg_pkg::QUO_W-1:0]   r_quo;
    logic                        r_ovf;
    logic [vrg_pkg::MASS_W:0]    div_t, div_d;
    logic                        div_ge;

    logic [CW-1:0]               r_k [3];
    logic [CW-1:0]               k_new;
    logic [2*CW-1:0]             r_kk;
    logic [vrg_pkg::CM_W-1:0]    r_b, r_a, cm;
    logic [vrg_pkg::NUM_W-1:0]   r_num;

    // box sizes: zero acts as one, oversize clamps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_y <= BW'(32);
            r_box_z <= BW'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vrg_pkg::CFG_BOX_Y: r_box_y <= i_cfg_data;
                vrg_pkg::CFG_BOX_Z: r_box_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign eff_y = (r_box_y == '0) ? BW'(1) : ((r_box_y > DIM_MAX) ? DIM_MAX : r_box_y);
    assign eff_z = (r_box_z == '0) ? BW'(1) : ((r_box_z > DIM_MAX) ? DIM_MAX : r_box_z);
    assign y_inc = {1'b0, r_cy} + 1'b1;
    assign z_inc = {1'b0, r_cz} + 1'b1;

    // raster counters, z fastest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_cx <= '0;
            r_cy <= '0;
            r_cz <= '0;
        end else if (i_cmd.take) begin
            if (z_inc >= eff_z) begin
                r_cz <= '0;
                if (y_inc >= eff_y) begin
                    r_cy <= '0;
                    r_cx <= r_cx + 1'b1;
                end else begin
                    r_cy <= y_inc[CW-1:0];
                end
            end else begin
                r_cz <= z_inc[CW-1:0];
            end
        end
    end

    assign cur_c[0] = r_cx;
    assign cur_c[1] = r_cy;
    assign cur_c[2] = r_cz;

    // first stage: register density, coordinates and their squares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= i_cmd.take;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v <= i_density;
        for (int i = 0; i < 3; i++) begin
            r_c[i]  <= cur_c[i];
            r_cs[i] <= cur_c[i] * cur_c[i];
        end
    end

    // second stage: accumulate mass and moments
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_m <= '0;
            for (int i = 0; i < 3; i++) begin
                r_s1[i] <= '0;
                r_s2[i] <= '0;
            end
        end else if (r_pv) begin
            r_m <= r_m + vrg_pkg::MASS_W'(r_v);
            for (int i = 0; i < 3; i++) begin
                r_s1[i] <= r_s1[i] + vrg_pkg::M1_W'(r_v * r_c[i]);
                r_s2[i] <= r_s2[i] + vrg_pkg::M2_W'(r_v * r_cs[i]);
            end
        end
    end

    assign o_sts.m_zero   = (r_m == '0);
    assign o_sts.out_busy = o_out_valid && !i_out_ready;

    // restoring divider by the mass, one quotient bit per cycle
    assign div_t  = {r_rem, r_dvd[vrg_pkg::DVD_W-1]};
    assign div_ge = (div_t >= {1'b0, r_m});
    assign div_d  = div_t - {1'b0, r_m};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_axis) begin
            r_rem <= '0;
            r_dvd <= vrg_pkg::DVD_W'(r_s1[i_cmd.axis]);
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.div_gyr) begin
            r_rem <= '0;
            r_dvd <= {r_num + vrg_pkg::NUM_W'(cm), {vrg_pkg::FRAC_W{1'b0}}};
            r_quo <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_d[vrg_pkg::MASS_W-1:0] : div_t[vrg_pkg::MASS_W-1:0];
            r_dvd <= {r_dvd[vrg_pkg::DVD_W-2:0], 1'b0};
            r_quo <= {r_quo[vrg_pkg::QUO_W-2:0], div_ge};
            r_ovf <= r_ovf | r_quo[vrg_pkg::QUO_W-1];
        end
    end

    // saturate the center at the grid edge
    assign k_new = (r_ovf || (|r_quo[vrg_pkg::QUO_W-1:CW])) ? K_SAT : r_quo[CW-1:0];

    // central moment per axis: S2 + k*k*M - 2k*S1, floored at zero
    always_ff @(posedge i_clk) begin
        if (i_cmd.k_lat) begin
            r_k[i_cmd.axis] <= k_new;
        end
        if (i_cmd.mul1) begin
            r_kk <= r_k[i_cmd.axis] * r_k[i_cmd.axis];
            r_b  <= vrg_pkg::CM_W'({r_k[i_cmd.axis], 1'b0} * r_s1[i_cmd.axis]);
        end
        if (i_cmd.mul2) begin
            r_a <= vrg_pkg::CM_W'(r_s2[i_cmd.axis]) + vrg_pkg::CM_W'(r_kk * r_m);
        end
        if (i_cmd.num_clr) begin
            r_num <= '0;
        end else if (i_cmd.num_add && !i_cmd.div_gyr) begin
            r_num <= r_num + vrg_pkg::NUM_W'(cm);
        end
    end

    assign cm = (r_a > r_b) ? (r_a - r_b) : '0;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_empty_grid <= i_cmd.out_empty;
            if (i_cmd.out_empty) begin
                o_mass        <= '0;
                o_center_x    <= '0;
                o_center_y    <= '0;
                o_center_z    <= '0;
                o_gyration_sq <= '0;
            end else begin
                o_mass        <= r_m;
                o_center_x    <= r_k[0];
                o_center_y    <= r_k[1];
                o_center_z    <= r_k[2];
                o_gyration_sq <= r_ovf ? '1 : r_quo;
            end
        end
    end

endmodule

[rtl/voxel_radius_of_gyration_core.sv]
// channel  | dir | handshake    | payload
// i_vox    | in  | valid/ready  | density[15:0], last
// o_res    | out | valid/ready  | mass[39:0], center_x/y/z[7:0], gyration_sq[33:0], empty_grid
//
// One voxel per cycle is taken while a grid streams in.
// After the last voxel, ready drops for the final computation: drain and check, per axis a
// 75-step restoring division, latch, the multiplies and an add, then a
// 75-step division for the gyration term and the final load, on one shared divider.
// An empty grid keeps ready low only through drain, check and the final load after its last voxel.
// Reset is synchronous, active low; it clears counters, sums and box sizes (32).
// A stalled result holds in the output register; the next grid may stream meanwhile,
// but its final load waits, with ready low, until the older result transfers.
module voxel_radius_of_gyration_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    vrg_in_if.sink                        i_vox,
    vrg_out_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [vrg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vrg_pkg::BOX_W-1:0]     i_cfg_data
);

    vrg_pkg::t_cmd cmd;
    vrg_pkg::t_sts sts;

    vrg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vox.valid),
        .i_last  (i_vox.last),
        .o_ready (i_vox.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    vrg_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_density     (i_vox.density),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_mass        (o_res.mass),
        .o_center_x    (o_res.center_x),
        .o_center_y    (o_res.center_y),
        .o_center_z    (o_res.center_z),
        .o_gyration_sq (o_res.gyration_sq),
        .o_empty_grid  (o_res.empty_grid)
    );

endmodule

[rtl/vrg_checker.sv]
module vrg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_in_last,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [vrg_pkg::MASS_W-1:0]  i_mass,
    input logic [vrg_pkg::COORD_W-1:0] i_cx,
    input logic                        i_empty
);

    // a waiting result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // no voxel taken right after the end of a grid
    a_busy_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("voxel taken during final computation");

    // empty grid gives zero mass and center_x
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_empty |-> (i_mass == '0) && (i_cx == '0))
        else $error("empty grid with nonzero fields");

    // a filled grid has mass
    a_mass_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_empty |-> (i_mass != '0))
        else $error("zero mass without empty flag");

endmodule

bind voxel_radius_of_gyration_core vrg_checker u_vrg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vox.valid),
    .i_in_ready  (i_vox.ready),
    .i_in_last   (i_vox.last),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_mass      (o_res.mass),
    .i_cx        (o_res.center_x),
    .i_empty     (o_res.empty_grid)
);

[sim/vrg_gyration_checker.sv]
module vrg_gyration_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    vrg_in_if                  i_vox,
    vrg_out_if                 o_res,
    input  logic               i_cfg_we,
    input  logic [vrg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [vrg_pkg::BOX_W-1:0]     i_cfg_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [vrg_pkg::MASS_W-1:0]  mass;
        logic [vrg_pkg::COORD_W-1:0] cx;
        logic [vrg_pkg::COORD_W-1:0] cy;
        logic [vrg_pkg::COORD_W-1:0] cz;
        logic [vrg_pkg::QUO_W-1:0]   gyr;
        logic                        empty;
    } t_grid_result;

    t_grid_result grid_results_q[$];

    logic [vrg_pkg::BOX_W-1:0]  size_y, size_z;
    logic [8:0]                 pos_x, pos_y, pos_z;
    logic [vrg_pkg::MASS_W-1:0] acc_mass;
    logic [vrg_pkg::M1_W-1:0]   acc_m1 [3];
    logic [vrg_pkg::M2_W-1:0]   acc_m2 [3];

    // clamp a box register to its usable range
    function automatic logic [9:0] span(input logic [vrg_pkg::BOX_W-1:0] b);
        if (b == '0) return 10'd1;
        if (b > vrg_pkg::BOX_W'(vrg_pkg::MAX_DIM)) return 10'(vrg_pkg::MAX_DIM);
        return {1'b0, b};
    endfunction

    // reduce the accumulated moments to a grid result
    function automatic t_grid_result summarize_grid();
        t_grid_result r;
        logic [63:0] m, k, a, b, num, q, rem, g;
        r = '0;
        m = 64'(acc_mass);
        num = '0;
        if (m == 0) begin
            r.empty = 1'b1;
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            k = 64'(acc_m1[i]) / m;
            if (k > 64'(vrg_pkg::MAX_DIM - 1)) k = 64'(vrg_pkg::MAX_DIM - 1);
            a = 64'(acc_m2[i]) + k * k * m;
            b = 64'd2 * k * 64'(acc_m1[i]);
            num += (a > b) ? a - b : 64'd0;
            if (i == 0) r.cx = k[7:0];
            else if (i == 1) r.cy = k[7:0];
            else r.cz = k[7:0];
        end
        q = num / m;
        rem = num % m;
        if (q > (64'h3_FFFF_FFFF >> 16)) begin
            g = 64'h3_FFFF_FFFF;
        end else begin
            g = (q << 16) + ((rem << 16) / m);
            if (g > 64'h3_FFFF_FFFF) g = 64'h3_FFFF_FFFF;
        end
        r.mass = acc_mass;
        r.gyr = g[vrg_pkg::QUO_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // track voxels, predict grid results, compare each result transfer
    always @(posedge i_clk) begin
        t_grid_result want;
        logic [63:0] v;
        if (!i_rst_n) begin
            size_y = 9'd32;
            size_z = 9'd32;
            pos_x = '0; pos_y = '0; pos_z = '0;
            acc_mass = '0;
            for (int i = 0; i < 3; i++) begin
                acc_m1[i] = '0;
                acc_m2[i] = '0;
            end
            grid_results_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == vrg_pkg::CFG_BOX_Y) size_y = i_cfg_data;
                else if (i_cfg_idx == vrg_pkg::CFG_BOX_Z) size_z = i_cfg_data;
            end
            if (o_res.valid && o_res.ready) begin
                if (grid_results_q.size() == 0) begin
                    report_mismatch("unexpected result, mass", 64'(o_res.mass), 64'd0);
                end else begin
                    want = grid_results_q.pop_front();
                    if (o_res.mass !== want.mass)
                        report_mismatch("mass", 64'(o_res.mass), 64'(want.mass));
                    if (o_res.center_x !== want.cx)
                        report_mismatch("center_x", 64'(o_res.center_x), 64'(want.cx));
                    if (o_res.center_y !== want.cy)
                        report_mismatch("center_y", 64'(o_res.center_y), 64'(want.cy));
                    if (o_res.center_z !== want.cz)
                        report_mismatch("center_z", 64'(o_res.center_z), 64'(want.cz));
                    if (o_res.gyration_sq !== want.gyr)
                        report_mismatch("gyration_sq", 64'(o_res.gyration_sq),
                                        64'(want.gyr));
                    if (o_res.empty_grid !== want.empty)
                        report_mismatch("empty_grid", 64'(o_res.empty_grid),
                                        64'(want.empty));
                end
            end
            if (i_vox.valid && i_vox.ready) begin
                v = 64'(i_vox.density);
                acc_mass += vrg_pkg::MASS_W'(v);
                acc_m1[0] += vrg_pkg::M1_W'(v * pos_x);
                acc_m1[1] += vrg_pkg::M1_W'(v * pos_y);
                acc_m1[2] += vrg_pkg::M1_W'(v * pos_z);
                acc_m2[0] += vrg_pkg::M2_W'(v * pos_x * pos_x);
                acc_m2[1] += vrg_pkg::M2_W'(v * pos_y * pos_y);
                acc_m2[2] += vrg_pkg::M2_W'(v * pos_z * pos_z);
                // advance raster position, z fastest
                pos_z++;
                if (pos_z >= span(size_z)) begin
                    pos_z = '0;
                    pos_y++;
                    if (pos_y >= span(size_y)) begin
                        pos_y = '0;
                        pos_x++;
                        if (pos_x >= vrg_pkg::MAX_DIM) pos_x = '0;
                    end
                end
                if (i_vox.last) begin
                    grid_results_q.insert(grid_results_q.size(), summarize_grid());
                    pos_x = '0; pos_y = '0; pos_z = '0;
                    acc_mass = '0;
                    for (int i = 0; i < 3; i++) begin
                        acc_m1[i] = '0;
                        acc_m2[i] = '0;
                    end
                end
            end
        end
        o_pending = grid_results_q.size();
    end

    initial o_fail_count = 0;
endmodule

[sim/voxel_radius_of_gyration_core_tb.sv]
module voxel_radius_of_gyration_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [vrg_pkg::CFG_IDX_W-1:0] i_cfg_idx = vrg_pkg::CFG_BOX_Y;
    logic [vrg_pkg::BOX_W-1:0] i_cfg_data = '0;
    int fail_count;
    int pending;
    int idle_pct = 0;
    int stall_pct = 0;
    int voxel_count = 0;

    vrg_in_if  vox_ch ();
    vrg_out_if res_ch ();

    voxel_radius_of_gyration_core dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vox     (vox_ch),
        .o_res     (res_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    vrg_gyration_checker checker_u (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vox       (vox_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        vox_ch.valid = 1'b0;
        vox_ch.density = '0;
        vox_ch.last = 1'b0;
        res_ch.ready = 1'b0;
    end

    // stall the result side at random
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // send one voxel, idling first at random; hold valid until transfer
    task automatic send_voxel(input logic [vrg_pkg::DENS_W-1:0] d, input logic lst);
        while ($urandom_range(99) < idle_pct) begin
            vox_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        vox_ch.valid <= 1'b1;
        vox_ch.density <= d;
        vox_ch.last <= lst;
        @(posedge i_clk);
        while (!vox_ch.ready) @(posedge i_clk);
        voxel_count++;
    endtask

    task automatic drain();
        vox_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [vrg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vrg_pkg::BOX_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // random density: mostly full range, sometimes extremes
    function automatic logic [vrg_pkg::DENS_W-1:0] pick_density();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return vrg_pkg::DENS_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // one grid: mostly one to three full boxes, sometimes shorter or longer
    task automatic send_grid(input int by, input int bz);
        int n;
        int full;
        full = (by == 0 ? 1 : by) * (bz == 0 ? 1 : bz) * $urandom_range(1, 3);
        if (full > 40) full = $urandom_range(1, 40);
        n = ($urandom_range(3) == 0) ? $urandom_range(1, 40) : full;
        for (int i = 0; i < n; i++)
            send_voxel(($urandom_range(7) == 0) ? 16'h0 : pick_density(), i == n - 1);
    endtask

    initial begin
        int by, bz;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty grid, extremes, single voxel, default box
        send_voxel(16'h0000, 1'b1);
        send_voxel(16'h0000, 1'b0);
        send_voxel(16'h0000, 1'b1);
        send_voxel(16'hFFFF, 1'b1);
        send_voxel(16'h0001, 1'b0);
        send_voxel(16'hFFFF, 1'b0);
        send_voxel(16'h8000, 1'b1);
        for (int i = 0; i < 6; i++) send_voxel(16'hFFFF >> i, i == 5);
        drain();

        // box of zero acts as one: x advances every voxel
        write_reg(vrg_pkg::CFG_BOX_Y, 9'd0);
        write_reg(vrg_pkg::CFG_BOX_Z, 9'd0);
        for (int i = 0; i < 8; i++) send_voxel(16'h5555 << (i & 1), i == 7);
        drain();
        // oversize boxes clamp to the maximum
        write_reg(vrg_pkg::CFG_BOX_Y, 9'h1FF);
        write_reg(vrg_pkg::CFG_BOX_Z, 9'h1FF);
        for (int i = 0; i < 6; i++) send_voxel(16'hAAAA, i == 5);
        drain();

        // random phases over box settings and idle and stall patterns
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 33; stall_pct = 33; end
            endcase
            by = (phase == 3) ? 256 : $urandom_range(0, 6);
            bz = (phase == 5) ? 1 : $urandom_range(0, 6);
            write_reg(vrg_pkg::CFG_BOX_Y, by[vrg_pkg::BOX_W-1:0]);
            write_reg(vrg_pkg::CFG_BOX_Z, bz[vrg_pkg::BOX_W-1:0]);
            while (voxel_count < 40 + (phase + 1) * 150) begin
                send_grid(by, bz);
                if ($urandom_range(9) == 0) drain();
            end
            drain();
        end

        idle_pct = 0;
        stall_pct = 0;
        drain();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("FAILURE");
        $finish;
    end
endmodule
